// ----- rtl/core/tnm_pkg.sv -----
// Package for the tile neighbour mask block: sequencer states, register
// indexes, tile code constants and the neighbour offset decode.
// No dependencies.
`default_nettype none

package tnm_pkg;

    localparam int CELL_W   = 6;
    localparam int CELL_MAX = (1 << CELL_W) - 1;
    localparam int CODE_W   = 8;
    localparam int SIDE_W   = 7;
    localparam int DIR_W    = 5;
    localparam int MASK_W   = 8;
    localparam int CFG_IDX_W = 3;
    localparam int NBR_W    = 3;

    localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WALL_A     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WALL_B     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WALL_C     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WALL_D     = 3'd5;

    localparam logic [CODE_W-1:0] CHAR_ZERO = 8'd48;
    localparam logic [CODE_W-1:0] CHAR_ONE  = 8'd49;
    localparam logic [CODE_W-1:0] CHAR_NINE = 8'd57;

    localparam logic       CMD_WRITE = 1'b0;
    localparam logic       CMD_QUERY = 1'b1;
    localparam logic [NBR_W-1:0] NBR_LAST = 3'd7;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WADDR,
        S_WRED,
        S_WMEM,
        S_SCAN,
        S_LAST,
        S_DONE
    } t_state;

    typedef struct packed {
        logic dx_neg;
        logic dx_pos;
        logic dy_neg;
        logic dy_pos;
    } t_nbr_off;

    // raster order around the centre, top-left first, centre skipped
    function automatic t_nbr_off nbr_offset(input logic [NBR_W-1:0] k);
        t_nbr_off o;
        o.dx_neg = (k == 3'd0) || (k == 3'd3) || (k == 3'd5);
        o.dx_pos = (k == 3'd2) || (k == 3'd4) || (k == 3'd7);
        o.dy_neg = (k <= 3'd2);
        o.dy_pos = (k >= 3'd5);
        return o;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/tnm_tile_ram.sv -----
// Single-port tile memory with registered read data.
// Depends on nothing; sized by the top level.
`default_nettype none

module tnm_tile_ram #(
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = 12,
    parameter int DATA_W = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_addr,
    input  wire logic [DATA_W-1:0] i_wdata,
    output logic      [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

`default_nettype wire

// ----- rtl/core/tile_neighbour_mask.sv -----
// Query: the eight neighbour reads, one per cycle, an evaluate of the last read, then
// the strobe. Write: address, the address wrap reduction steps (none at MAX_SIDE = 64),
// memory write, strobe; query on an empty map: strobe only. Busy holds off start until
// the last request is through. The single-port tile memory sets the query rate.
// Results cannot be stalled. Reset (synchronous, active low) clears control,
// registers and the loaded flag.
`default_nettype none

module tile_neighbour_mask #(
    parameter int MAX_SIDE = 64
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic                           i_cmd,
    input  wire logic [tnm_pkg::CELL_W-1:0]     i_cell_x,
    input  wire logic [tnm_pkg::CELL_W-1:0]     i_cell_y,
    input  wire logic [tnm_pkg::CODE_W-1:0]     i_tile_code,
    output logic                                o_valid,
    output logic [tnm_pkg::MASK_W-1:0]          o_wall_mask,
    output logic signed [tnm_pkg::DIR_W-1:0]    o_direction,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [tnm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [tnm_pkg::CODE_W-1:0]     i_cfg_data
);
    import tnm_pkg::*;

    localparam int MS2  = MAX_SIDE * MAX_SIDE;
    localparam int AW   = $clog2(MS2);
    localparam int VMAX = CELL_MAX * MAX_SIDE + CELL_MAX;
    localparam int VW   = $clog2(VMAX + 1);
    localparam int CW   = ((VW > AW) ? VW : AW) + 2;
    localparam int QMAX = VMAX / MS2;
    localparam int KS   = $clog2(QMAX + 1);
    localparam int KCW  = (KS > 1) ? $clog2(KS) : 1;
    localparam int SW   = (($clog2(MAX_SIDE + 1) > SIDE_W) ? $clog2(MAX_SIDE + 1) : SIDE_W) + 1;

    // configuration
    logic [SIDE_W-1:0] r_map_width, r_map_height;
    logic [CODE_W-1:0] r_wall_a, r_wall_b, r_wall_c, r_wall_d;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_width  <= 7'd64;
            r_map_height <= 7'd64;
            r_wall_a     <= '0;
            r_wall_b     <= '0;
            r_wall_c     <= '0;
            r_wall_d     <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_MAP_WIDTH:  r_map_width  <= i_cfg_data[SIDE_W-1:0];
                REG_MAP_HEIGHT: r_map_height <= i_cfg_data[SIDE_W-1:0];
                REG_WALL_A:     r_wall_a     <= i_cfg_data;
                REG_WALL_B:     r_wall_b     <= i_cfg_data;
                REG_WALL_C:     r_wall_c     <= i_cfg_data;
                REG_WALL_D:     r_wall_d     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer state
    t_state r_state, n_state;
    logic   r_cmd;
    logic [CELL_W-1:0] r_x, r_y;
    logic [CODE_W-1:0] r_code;
    logic   r_loaded, n_loaded;
    logic [NBR_W-1:0] r_k, n_k;
    logic [KCW-1:0] r_rk, n_rk;
    logic [CW-1:0]  r_v, n_v;
    logic [NBR_W-1:0] r_pk, n_pk;
    logic   r_pout, n_pout;
    logic   r_pv, n_pv;
    logic   r_found, n_found;
    logic [MASK_W-1:0] r_mask, n_mask;
    logic signed [DIR_W-1:0] r_dir, n_dir;
    logic   r_ovalid, n_ovalid;

    // neighbour position and bounds
    t_nbr_off off, poff;
    logic [SIDE_W-1:0] nx, ny;
    logic [SW-1:0] w_lim, h_lim;
    logic outside;
    logic [CW-1:0] mul_row, mul_col, addr_sum, red_step;

    // memory port
    logic            ram_we;
    logic [AW-1:0]   ram_addr;
    logic [CODE_W-1:0] ram_rdata;

    // evaluation of the previous read
    logic is_wall, is_digit, p_wall;
    logic signed [DIR_W-1:0] digit;

    assign off  = nbr_offset(r_k);
    assign poff = nbr_offset(r_pk);

    always_comb begin
        nx = {1'b0, r_x};
        ny = {1'b0, r_y};
        if (off.dx_neg) nx = {1'b0, r_x} - 7'd1;
        if (off.dx_pos) nx = {1'b0, r_x} + 7'd1;
        if (off.dy_neg) ny = {1'b0, r_y} - 7'd1;
        if (off.dy_pos) ny = {1'b0, r_y} + 7'd1;
    end

    assign w_lim = (SW'(r_map_width) > SW'(MAX_SIDE)) ? SW'(MAX_SIDE) : SW'(r_map_width);
    assign h_lim = (SW'(r_map_height) > SW'(MAX_SIDE)) ? SW'(MAX_SIDE) : SW'(r_map_height);

    assign outside = (off.dx_neg && (r_x == '0)) || (off.dy_neg && (r_y == '0)) ||
                     (SW'(nx) >= w_lim) || (SW'(ny) >= h_lim);

    // shared row * MAX_SIDE + column unit for write and read addresses
    assign mul_row  = (r_state == S_SCAN) ? CW'(ny) : CW'(r_y);
    assign mul_col  = (r_state == S_SCAN) ? CW'(nx) : CW'(r_x);
    assign addr_sum = mul_row * CW'(MAX_SIDE) + mul_col;
    assign red_step = CW'(MS2) << r_rk;

    assign ram_we   = (r_state == S_WMEM);
    assign ram_addr = (r_state == S_SCAN) ? addr_sum[AW-1:0] : r_v[AW-1:0];

    tnm_tile_ram #(
        .DEPTH  (MS2),
        .ADDR_W (AW),
        .DATA_W (CODE_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (r_code),
        .o_rdata (ram_rdata)
    );

    assign is_wall  = (ram_rdata == r_wall_a) || (ram_rdata == r_wall_b) ||
                      (ram_rdata == r_wall_c) || (ram_rdata == r_wall_d);
    assign is_digit = (ram_rdata >= CHAR_ONE) && (ram_rdata <= CHAR_NINE);
    assign p_wall   = r_pout || is_wall;
    assign digit    = DIR_W'(ram_rdata - CHAR_ZERO);

    always_comb begin
        n_state  = r_state;
        n_loaded = r_loaded;
        n_k      = r_k;
        n_rk     = r_rk;
        n_v      = r_v;
        n_pk     = r_pk;
        n_pout   = r_pout;
        n_pv     = r_pv;
        n_found  = r_found;
        n_mask   = r_mask;
        n_dir    = r_dir;
        n_ovalid = 1'b0;

        // fold in the neighbour read in the previous cycle
        if ((r_state == S_SCAN || r_state == S_LAST) && r_pv) begin
            if (p_wall) begin
                n_mask[r_pk] = 1'b1;
            end
            if (!r_pout && is_digit && !r_found) begin
                n_found = 1'b1;
                n_dir   = poff.dx_neg ? -digit : digit;
            end
        end

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_mask  = '0;
                    n_dir   = '0;
                    n_found = 1'b0;
                    n_pv    = 1'b0;
                    n_k     = '0;
                    if (i_cmd == CMD_WRITE) begin
                        n_state = S_WADDR;
                    end else if (r_loaded) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_WADDR: begin
                n_v     = addr_sum;
                n_rk    = KCW'(KS - 1);
                n_state = (KS > 0) ? S_WRED : S_WMEM;
            end
            S_WRED: begin
                // wrap the absolute position into the store, one binary step a cycle
                if (r_v >= red_step) begin
                    n_v = r_v - red_step;
                end
                if (r_rk == '0) begin
                    n_state = S_WMEM;
                end else begin
                    n_rk = r_rk - KCW'(1);
                end
            end
            S_WMEM: begin
                n_loaded = 1'b1;
                n_state  = S_DONE;
            end
            S_SCAN: begin
                n_pk   = r_k;
                n_pout = outside;
                n_pv   = 1'b1;
                n_k    = r_k + NBR_W'(1);
                if (r_k == NBR_LAST) begin
                    n_state = S_LAST;
                end
            end
            S_LAST: begin
                n_ovalid = 1'b1;
                n_state  = S_IDLE;
            end
            S_DONE: begin
                n_ovalid = 1'b1;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_loaded <= 1'b0;
            r_ovalid <= 1'b0;
            r_pv     <= 1'b0;
            r_found  <= 1'b0;
            r_k      <= '0;
            r_rk     <= '0;
        end else begin
            r_state  <= n_state;
            r_loaded <= n_loaded;
            r_ovalid <= n_ovalid;
            r_pv     <= n_pv;
            r_found  <= n_found;
            r_k      <= n_k;
            r_rk     <= n_rk;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && start) begin
            r_cmd  <= i_cmd;
            r_x    <= i_cell_x;
            r_y    <= i_cell_y;
            r_code <= i_tile_code;
        end
        r_v    <= n_v;
        r_pk   <= n_pk;
        r_pout <= n_pout;
        r_mask <= n_mask;
        r_dir  <= n_dir;
    end

    assign busy        = (r_state != S_IDLE);
    assign o_valid     = r_ovalid;
    // a write request always answers zero
    assign o_wall_mask = (r_cmd == CMD_QUERY) ? r_mask : '0;
    assign o_direction = (r_cmd == CMD_QUERY) ? r_dir : '0;

endmodule

`default_nettype wire

// ----- rtl/core/tnm_checker.sv -----
// Port-level checks for tile_neighbour_mask, attached by bind.
// Depends on tnm_pkg for field widths.
`default_nettype none

module tnm_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           start,
    input wire logic                           busy,
    input wire logic                           o_valid,
    input wire logic [tnm_pkg::MASK_W-1:0]     o_wall_mask,
    input wire logic signed [tnm_pkg::DIR_W-1:0] o_direction
);
    import tnm_pkg::*;

    // a result strobe never repeats back to back
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held for two cycles");

    // an accepted request makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted but block not busy");

    // finishing a request coincides with its result
    a_done_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_valid)
        else $error("busy dropped without a result");

    // direction stays within signed digit range
    a_dir_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_direction >= -5'sd9 && o_direction <= 5'sd9))
        else $error("direction out of range");

    // a strobed result carries no unknown bits
    a_result_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !$isunknown({o_wall_mask, o_direction}))
        else $error("result carries unknown bits");

endmodule

bind tile_neighbour_mask tnm_checker u_tnm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_valid     (o_valid),
    .o_wall_mask (o_wall_mask),
    .o_direction (o_direction)
);

`default_nettype wire
